@@ rtl/core/spmh_pkg.sv @@
// Shared types and constants for the streaming pattern match highlighter.
package spmh_pkg;

  // Default sizing of the window and the cell counter
  localparam int DEF_MAX_PATTERN = 8;
  localparam int DEF_CELL_COUNT  = 16384;

  // Fixed field widths
  localparam int CHAR_W     = 8;
  localparam int PLEN_W     = 4;
  localparam int PCHARS_W   = 64;
  localparam int START_W    = 14;
  localparam int S_TDATA_W  = 8;
  localparam int M_TDATA_W  = 16;
  localparam int APB_DATA_W = 64;
  localparam int APB_ADDR_W = 4;

  // Register index codes, taken from paddr[3] (registers sit 8 bytes apart)
  typedef enum logic {
    REG_PATTERN_CHARS  = 1'b0,
    REG_PATTERN_LENGTH = 1'b1
  } reg_idx_t;

  // Configuration seen by the match datapath
  typedef struct packed {
    logic [PCHARS_W-1:0] pattern_chars;
    logic [PLEN_W-1:0]   pattern_length;
  } cfg_t;

  // One input word held in the input register
  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              start_scan;
    logic              last_cell;
  } item_t;

  // Match result from the datapath
  typedef struct packed {
    logic               match_found;
    logic [START_W-1:0] match_start;
  } match_t;

endpackage

@@ rtl/core/streaming_pattern_match_highlight.sv @@
// Top level: stream ports, input register, match datapath and result register.
// Takes one character word per cycle while the output side is ready and returns
// one result word per character, through the input register and then the result
// register. These two registers form a two-deep pipeline, so a word is still taken
// into an empty input register while a finished result waits; the window shift and
// the per-length byte compares sit between them and set the throughput. Each
// result says whether the configured pattern ends at that cell and, if so, the
// index of its first cell. Write the pattern registers only while no words are in
// flight.
module streaming_pattern_match_highlight
  import spmh_pkg::*;
#(
  parameter int MAX_PATTERN = DEF_MAX_PATTERN,
  parameter int CELL_COUNT  = DEF_CELL_COUNT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // [7:0] char_code
  input  logic                  s_axis_tuser,  // [0] start_scan
  input  logic                  s_axis_tlast,  // last_cell
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [M_TDATA_W-1:0]  m_axis_tdata,  // [13:0] match_start, [15:14] zero
  output logic                  m_axis_tuser,  // [0] match_found
  output logic                  m_axis_tlast,  // scan_end
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t   cfg;
  item_t  in_item;
  logic   in_valid;
  logic   advance;
  match_t result;

  spmh_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Move the held word into the result register when it is free or draining
  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // Capture an incoming word
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.char_code  <= s_axis_tdata[CHAR_W-1:0];
      in_item.start_scan <= s_axis_tuser;
      in_item.last_cell  <= s_axis_tlast;
    end
  end

  spmh_match #(
    .MAX_PATTERN (MAX_PATTERN),
    .CELL_COUNT  (CELL_COUNT)
  ) u_match (
    .clk    (clk),
    .rst    (rst),
    .take   (advance),
    .item   (in_item),
    .cfg    (cfg),
    .result (result)
  );

  // Hold the result word until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (!m_axis_tvalid || m_axis_tready) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= M_TDATA_W'(result.match_start);
      m_axis_tuser <= result.match_found;
      m_axis_tlast <= in_item.last_cell;
    end
  end

endmodule

@@ rtl/core/spmh_cfg.sv @@
// APB register file holding the pattern bytes and the pattern length.
module spmh_cfg
  import spmh_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic     wr_en;
  reg_idx_t reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = reg_idx_t'(paddr[3]);

  // Write the selected register on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_PATTERN_CHARS:  cfg.pattern_chars  <= pwdata[PCHARS_W-1:0];
        REG_PATTERN_LENGTH: cfg.pattern_length <= pwdata[PLEN_W-1:0];
        default:            cfg <= cfg;
      endcase
    end
  end

  // Return the addressed register, zero for unaligned addresses
  always_comb begin
    prdata = '0;
    if (paddr[2:0] == 3'd0) begin
      unique case (reg_sel)
        REG_PATTERN_CHARS:  prdata = APB_DATA_W'(cfg.pattern_chars);
        REG_PATTERN_LENGTH: prdata = APB_DATA_W'(cfg.pattern_length);
        default:            prdata = '0;
      endcase
    end
  end

endmodule

@@ rtl/core/spmh_match.sv @@
// Character window, fill count, cell counter and parallel pattern compare.
module spmh_match
  import spmh_pkg::*;
#(
  parameter int MAX_PATTERN = DEF_MAX_PATTERN,
  parameter int CELL_COUNT  = DEF_CELL_COUNT
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   take,
  input  item_t  item,
  input  cfg_t   cfg,
  output match_t result
);

  localparam int IDX_W  = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int FILL_W = $clog2(MAX_PATTERN + 1);

  logic [CHAR_W-1:0] char_window [MAX_PATTERN];
  logic [FILL_W-1:0] window_fill;
  logic [IDX_W-1:0]  cell_index;

  logic [CHAR_W-1:0] char_window_next [MAX_PATTERN];
  logic [FILL_W-1:0] window_fill_next;
  logic [IDX_W-1:0]  cell_index_next;

  logic [FILL_W-1:0] fill_base;
  logic [IDX_W-1:0]  here;
  logic [IDX_W-1:0]  len_m1;
  logic [IDX_W:0]    wrap_sum;
  logic [IDX_W-1:0]  first;
  logic [MAX_PATTERN-1:0] hit_len;
  logic              len_ok;
  logic              hit;

  // Shift the new character in, starting from a clear window on start_scan
  always_comb begin
    char_window_next[0] = item.char_code;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      char_window_next[k] = item.start_scan ? '0 : char_window[k-1];
    end
    fill_base = item.start_scan ? '0 : window_fill;
    window_fill_next = (fill_base < FILL_W'(MAX_PATTERN)) ? fill_base + 1'b1 : fill_base;
    here = item.start_scan ? '0 : cell_index;
    cell_index_next = (here == IDX_W'(CELL_COUNT - 1)) ? '0 : here + 1'b1;
  end

  // Compare every candidate length against the shifted window
  always_comb begin
    for (int l = 0; l < MAX_PATTERN; l++) begin
      hit_len[l] = 1'b1;
      for (int i = 0; i <= l; i++) begin
        if (char_window_next[l-i] != cfg.pattern_chars[CHAR_W*i +: CHAR_W]) begin
          hit_len[l] = 1'b0;
        end
      end
    end
  end

  // Pick the configured length and work out where the match began
  always_comb begin
    len_ok = (cfg.pattern_length != '0) &&
             (cfg.pattern_length <= PLEN_W'(MAX_PATTERN)) &&
             (PLEN_W'(window_fill_next) >= cfg.pattern_length);
    hit = 1'b0;
    for (int l = 0; l < MAX_PATTERN; l++) begin
      if (cfg.pattern_length == PLEN_W'(l + 1)) begin
        hit = hit_len[l];
      end
    end
    hit = hit && len_ok;
    len_m1 = IDX_W'(cfg.pattern_length - 1'b1);
    wrap_sum = (IDX_W+1)'(here) + (IDX_W+1)'(CELL_COUNT) - (IDX_W+1)'(len_m1);
    first = (here >= len_m1) ? here - len_m1 : wrap_sum[IDX_W-1:0];
    result.match_found = hit;
    result.match_start = hit ? START_W'(first) : '0;
  end

  // Advance the scan state on each word taken
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
        char_window[k] <= '0;
      end
      window_fill <= '0;
      cell_index  <= '0;
    end else if (take) begin
      char_window <= char_window_next;
      window_fill <= window_fill_next;
      cell_index  <= cell_index_next;
    end
  end

endmodule

@@ rtl/core/spmh_checker.sv @@
// Port-level checks for the pattern match highlighter, bound to the top level.
module spmh_checker
  import spmh_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata,
  input logic                 m_axis_tuser,
  input logic                 m_axis_tlast
);

  // Pipeline comes out of reset empty and ready
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (s_axis_tready && !m_axis_tvalid))
    else $error("pipeline not empty after reset");

  // A stalled result word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
       $stable(m_axis_tlast)))
    else $error("result word changed while stalled");

  // Match start reads zero when no match is reported
  a_start_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("match start set without a match");

  // Padding bits above match start stay clear
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[M_TDATA_W-1:START_W] == '0))
    else $error("result padding bits set");

endmodule

bind streaming_pattern_match_highlight spmh_checker u_spmh_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

@@ tb/sv/match_checker.sv @@
// Checker for the pattern match highlighter: tracks the registers, predicts each result word, compares.
module match_checker
  import spmh_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // [7:0] char_code
  input  logic                  s_axis_tuser,  // [0] start_scan
  input  logic                  s_axis_tlast,  // last_cell
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [M_TDATA_W-1:0]  m_axis_tdata,  // [13:0] match_start, [15:14] zero
  input  logic                  m_axis_tuser,  // [0] match_found
  input  logic                  m_axis_tlast,  // scan_end
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic                  pready,
  output int                    fail_count,
  output int                    results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic               found;
    logic [START_W-1:0] first_cell;
    logic               scan_end;
  } cell_result_t;

  // Shadow of the pattern registers and of the scan state
  logic [PCHARS_W-1:0] pat_chars = '0;
  logic [PLEN_W-1:0]   pat_len = '0;
  logic [CHAR_W-1:0]   window [DEF_MAX_PATTERN];
  int                  fill;
  int                  cell_idx;
  cell_result_t        owed_results [$];
  int                  errs = 0;

  // Empty the window and restart the cell count
  function automatic void clear_window();
    int k;
    for (k = 0; k < DEF_MAX_PATTERN; k++) window[k] = '0;
    fill     = 0;
    cell_idx = 0;
  endfunction

  // Shift one cell into the window and work out its result word
  function automatic cell_result_t scan_cell(logic [CHAR_W-1:0] ch, logic start, logic last);
    cell_result_t r;
    logic         hit;
    int           k;
    if (start) clear_window();
    for (k = DEF_MAX_PATTERN - 1; k > 0; k--) window[k] = window[k-1];
    window[0] = ch;
    if (fill < DEF_MAX_PATTERN) fill++;
    // The pattern must be enabled, fit the window, and have all its cells received
    hit = (pat_len != 0) && (pat_len <= DEF_MAX_PATTERN) && (fill >= pat_len);
    if (hit) begin
      for (k = 0; k < pat_len; k++) begin
        if (window[pat_len - 1 - k] != pat_chars[CHAR_W*k +: CHAR_W]) hit = 1'b0;
      end
    end
    r.found      = hit;
    r.first_cell = hit ? START_W'((cell_idx + DEF_CELL_COUNT - pat_len + 1) % DEF_CELL_COUNT)
                       : '0;
    r.scan_end   = last;
    cell_idx     = (cell_idx + 1) % DEF_CELL_COUNT;
    return r;
  endfunction

  always @(posedge clk) begin
    cell_result_t             want;
    logic [M_TDATA_W-1:0]     want_data;
    if (rst) begin
      pat_chars = '0;
      pat_len   = '0;
      clear_window();
      owed_results.delete();
    end else begin
      // Track register writes
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3]))
          REG_PATTERN_CHARS:  pat_chars = pwdata[PCHARS_W-1:0];
          REG_PATTERN_LENGTH: pat_len   = pwdata[PLEN_W-1:0];
          default: ;
        endcase
      end
      // Compare an outgoing word with the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        if (owed_results.size() == 0) begin
          $display("%0t: unexpected result word: tdata %h tuser %b tlast %b",
                   $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
          errs++;
        end else begin
          want      = owed_results.pop_front();
          want_data = '0;
          want_data[START_W-1:0] = want.first_cell;
          if (m_axis_tuser !== want.found) begin
            $display("%0t: match_found mismatch: expected %b, actual %b",
                     $time, want.found, m_axis_tuser);
            errs++;
          end
          if (m_axis_tdata !== want_data) begin
            $display("%0t: match_start word mismatch: expected %h, actual %h",
                     $time, want_data, m_axis_tdata);
            errs++;
          end
          if (m_axis_tlast !== want.scan_end) begin
            $display("%0t: scan_end mismatch: expected %b, actual %b",
                     $time, want.scan_end, m_axis_tlast);
            errs++;
          end
        end
      end
      // Predict the result of an accepted cell
      if (s_axis_tvalid && s_axis_tready)
        owed_results.push_back(scan_cell(s_axis_tdata[CHAR_W-1:0], s_axis_tuser, s_axis_tlast));
    end
    fail_count   <= errs;
    results_owed <= owed_results.size();
  end

endmodule

@@ tb/sv/testbench.sv @@
// Top of the testbench: clock, reset, stimulus, output back-pressure and the verdict.
module testbench
  import spmh_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 400000;
  localparam int PHASES       = 12;
  localparam int PHASE_CELLS  = 75;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata = '0;  // [7:0] char_code
  logic                  s_axis_tuser = 1'b0;  // [0] start_scan
  logic                  s_axis_tlast = 1'b0;  // last_cell
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;  // [13:0] match_start, [15:14] zero
  logic                  m_axis_tuser;  // [0] match_found
  logic                  m_axis_tlast;  // scan_end
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int          fail_count;
  int          results_owed;
  bit          no_idle = 1'b0;
  int          sink_wait = 0;
  int unsigned cycles = 0;

  always #2 clk = ~clk;

  streaming_pattern_match_highlight dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  match_checker checker_i (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .fail_count(fail_count), .results_owed(results_owed)
  );

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Stall the result side for a random number of cycles after each word
  always @(posedge clk) begin
    int stall;
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_wait     <= 0;
    end else if (m_axis_tready && m_axis_tvalid) begin
      stall = no_idle ? 0 : $urandom_range(0, 13);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        sink_wait     <= stall;
      end
    end else if (!m_axis_tready) begin
      if (sink_wait > 1) sink_wait <= sink_wait - 1;
      else m_axis_tready <= 1'b1;
    end
  end

  // Offer one cell word after a random gap and hold it until taken
  task automatic send_cell(input logic [CHAR_W-1:0] ch, input logic start, input logic last);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tuser  <= start;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Stop sending and wait until every predicted word has come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write: setup cycle, access cycle, then idle
  task automatic write_reg(input reg_idx_t idx, input logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [PCHARS_W-1:0] pat;
    logic [CHAR_W-1:0]   alpha [4];
    logic [CHAR_W-1:0]   ch;
    int                  len;
    int                  run;
    int                  bad;
    int                  sent;
    int                  ph;
    int                  k;
    int                  n;
    bit                  held;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Zero length never matches, not even a zero pattern on zero cells
    send_cell(8'h00, 1'b1, 1'b0);
    send_cell(8'h00, 1'b0, 1'b0);
    wait_drained();

    // Three characters with both byte extremes: overlaps, scan end, restart
    write_reg(REG_PATTERN_CHARS, 64'h0000_0000_00FF_00FF);
    write_reg(REG_PATTERN_LENGTH, 64'd3);
    send_cell(8'hFF, 1'b1, 1'b0);
    send_cell(8'h00, 1'b0, 1'b0);
    send_cell(8'hFF, 1'b0, 1'b0);
    send_cell(8'h00, 1'b0, 1'b0);
    send_cell(8'hFF, 1'b0, 1'b1);
    // cells after the last one keep the same scan going
    send_cell(8'h00, 1'b0, 1'b0);
    send_cell(8'hFF, 1'b0, 1'b0);
    // a restart empties the window, so this pair cannot complete a match
    send_cell(8'h00, 1'b1, 1'b0);
    send_cell(8'hFF, 1'b0, 1'b0);
    wait_drained();

    // Longest pattern, matched from the first cell of a scan
    pat = 64'hF0E1_D2C3_B4A5_9687;
    write_reg(REG_PATTERN_CHARS, pat);
    write_reg(REG_PATTERN_LENGTH, 64'd8);
    for (k = 0; k < 8; k++) send_cell(pat[CHAR_W*k +: CHAR_W], k == 0, k == 7);
    wait_drained();

    // Length above the window never matches
    write_reg(REG_PATTERN_LENGTH, 64'd15);
    send_cell(8'h87, 1'b0, 1'b0);
    wait_drained();

    // Single character: every equal cell is its own match
    write_reg(REG_PATTERN_CHARS, 64'h41);
    write_reg(REG_PATTERN_LENGTH, 64'd1);
    send_cell(8'h41, 1'b0, 1'b0);
    send_cell(8'h41, 1'b0, 1'b1);
    wait_drained();

    // Random phases: mostly planted pattern runs, some broken, plus noise
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       len = 0;
        1:       len = 8;
        2:       len = 9;
        3:       len = 15;
        4:       len = 1;
        default: len = $urandom_range(1, 8);
      endcase
      if ($urandom_range(0, 1) == 0) begin
        alpha[0] = 8'h00;
        alpha[1] = 8'hFF;
        alpha[2] = $urandom_range(0, 255);
        alpha[3] = $urandom_range(0, 255);
      end else begin
        for (k = 0; k < 4; k++) alpha[k] = $urandom_range(0, 255);
      end
      for (k = 0; k < 8; k++) pat[CHAR_W*k +: CHAR_W] = alpha[$urandom_range(0, 3)];
      no_idle = (ph % 4 == 3);
      if ($urandom_range(0, 1) == 0) begin
        write_reg(REG_PATTERN_CHARS, pat);
        write_reg(REG_PATTERN_LENGTH, APB_DATA_W'(len));
      end else begin
        write_reg(REG_PATTERN_LENGTH, APB_DATA_W'(len));
        write_reg(REG_PATTERN_CHARS, pat);
      end

      sent = 0;
      held = 1'b0;
      while (sent < PHASE_CELLS) begin
        // hold the sender once per phase until the output side catches up
        if (!held && sent >= PHASE_CELLS / 2) begin
          wait_drained();
          held = 1'b1;
        end
        if ($urandom_range(0, 9) < 6) begin
          run = (len >= 1 && len <= 8) ? len : 8;
          bad = ($urandom_range(0, 4) == 0) ? $urandom_range(0, run - 1) : -1;
          for (k = 0; k < run; k++) begin
            ch = (k == bad) ? 8'($urandom_range(0, 255)) : pat[CHAR_W*k +: CHAR_W];
            send_cell(ch, $urandom_range(0, 31) == 0, $urandom_range(0, 15) == 0);
            sent++;
          end
        end else begin
          n = $urandom_range(1, 4);
          for (k = 0; k < n; k++) begin
            ch = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255))
                                             : alpha[$urandom_range(0, 3)];
            send_cell(ch, $urandom_range(0, 31) == 0, $urandom_range(0, 15) == 0);
            sent++;
          end
        end
      end
      wait_drained();
    end

    // Let the pipeline settle, then give the verdict
    no_idle = 1'b0;
    repeat (8) @(posedge clk);
    if (fail_count == 0 && results_owed == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
